@@ src/segment_intersection_3d_defines.svh @@
// Assertion macros shared by the checker of the segment intersection block.
`ifndef SEGMENT_INTERSECTION_3D_DEFINES_SVH
`define SEGMENT_INTERSECTION_3D_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sid_pkg.sv @@
// Types, constants and helpers of the segment intersection block.
package sid_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int DET_W         = PROD_W + 1;
    localparam int QUOT_W        = COORD_W + 1;
    localparam int DET_TOL_W     = 63;
    localparam int RES_TOL_W     = 32;
    localparam int CFG_DATA_W    = 63;

    typedef enum logic [0:0] {
        CFG_DET_TOL = 1'b0,
        CFG_RES_TOL = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_NO      = 2'd0,
        ST_YES     = 2'd1,
        ST_ON_LINE = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_start_z;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] first_end_z;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_start_z;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
        logic signed [COORD_W-1:0] second_end_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [COORD_W-1:0] param_first;
        logic signed [COORD_W-1:0] param_second;
    } t_out_item;

    // Sideband that rides along the divider
    typedef struct packed {
        logic                     solved;
        logic                     neg_u;
        logic                     neg_v;
        logic signed [DIFF_W-1:0] da;
        logic signed [DIFF_W-1:0] db;
        logic signed [DIFF_W-1:0] wc;
    } t_side;

    function automatic logic [DET_W-1:0] abs_det(input logic signed [DET_W-1:0] x);
        abs_det = x[DET_W-1] ? DET_W'(-x) : DET_W'(x);
    endfunction

endpackage

@@ src/sid_div.sv @@
// Pipelined restoring divider: two numerators over one divisor, one quotient bit a stage.
module sid_div
    import sid_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_vld,
    input  logic [DET_W-1:0]           i_num_u,
    input  logic [DET_W-1:0]           i_num_v,
    input  logic [DET_W-1:0]           i_den,
    input  t_side                      i_side,
    output logic                       o_vld,
    output logic [QUOT_W-1:0]          o_quot_u,
    output logic                       o_ovf_u,
    output logic [QUOT_W-1:0]          o_quot_v,
    output logic                       o_ovf_v,
    output t_side                      o_side
);

    localparam int NUM_W = DET_W + COORD_FRAC_BITS;
    localparam int CW    = DET_W + QUOT_W;
    localparam int OW    = ((NUM_W > CW) ? NUM_W : CW) + 1;

    logic              r_vld  [QUOT_W+1];
    logic [CW-1:0]     r_rem_u[QUOT_W+1];
    logic [CW-1:0]     r_rem_v[QUOT_W+1];
    logic [QUOT_W-1:0] r_q_u  [QUOT_W+1];
    logic [QUOT_W-1:0] r_q_v  [QUOT_W+1];
    logic              r_ovf_u[QUOT_W+1];
    logic              r_ovf_v[QUOT_W+1];
    logic [DET_W-1:0]  r_den  [QUOT_W+1];
    t_side             r_side [QUOT_W+1];

    logic [NUM_W-1:0] nu_sh;
    logic [NUM_W-1:0] nv_sh;
    logic [OW-1:0]    den_top;
    logic             n_ovf_u;
    logic             n_ovf_v;

    // Scale numerators and flag quotients that do not fit the quotient width
    always_comb begin
        nu_sh   = {i_num_u, COORD_FRAC_BITS'(0)};
        nv_sh   = {i_num_v, COORD_FRAC_BITS'(0)};
        den_top = OW'(i_den) << QUOT_W;
        n_ovf_u = OW'(nu_sh) >= den_top;
        n_ovf_v = OW'(nv_sh) >= den_top;
    end

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem_u[0] <= n_ovf_u ? '0 : CW'(nu_sh);
            r_rem_v[0] <= n_ovf_v ? '0 : CW'(nv_sh);
            r_q_u[0]   <= '0;
            r_q_v[0]   <= '0;
            r_ovf_u[0] <= n_ovf_u;
            r_ovf_v[0] <= n_ovf_v;
            r_den[0]   <= i_den;
            r_side[0]  <= i_side;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
        localparam int BIT = QUOT_W - 1 - k;
        logic [CW-1:0] trial;
        logic          take_u;
        logic          take_v;

        always_comb begin
            trial  = CW'(r_den[k]) << BIT;
            take_u = r_rem_u[k] >= trial;
            take_v = r_rem_v[k] >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem_u[k+1] <= take_u ? r_rem_u[k] - trial : r_rem_u[k];
                r_rem_v[k+1] <= take_v ? r_rem_v[k] - trial : r_rem_v[k];
                r_q_u[k+1]   <= r_q_u[k] | (QUOT_W'(take_u) << BIT);
                r_q_v[k+1]   <= r_q_v[k] | (QUOT_W'(take_v) << BIT);
                r_ovf_u[k+1] <= r_ovf_u[k];
                r_ovf_v[k+1] <= r_ovf_v[k];
                r_den[k+1]   <= r_den[k];
                r_side[k+1]  <= r_side[k];
            end
        end
    end

    assign o_vld    = r_vld[QUOT_W];
    assign o_quot_u = r_q_u[QUOT_W];
    assign o_ovf_u  = r_ovf_u[QUOT_W];
    assign o_quot_v = r_q_v[QUOT_W];
    assign o_ovf_v  = r_ovf_v[QUOT_W];
    assign o_side   = r_side[QUOT_W];

endmodule

@@ src/segment_intersection_3d.sv @@
// Top level of the 3D segment intersection pipeline.
// Takes one segment pair per cycle when the output is not stalled and returns
// one result per pair: four stages form the differences, the twelve 33x33
// products, the determinants and numerators, and pick the xy or xz system;
// the divider spends one stage on its range check and one stage on each of the
// 33 quotient bits; three more stages saturate u and v, multiply them back and
// test the left-out axis and the [0, 1] range. A stall of a valid output
// freezes the whole pipeline. Configuration writes are always ready.
module segment_intersection_3d
    import sid_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MUL_W = COORD_W + DIFF_W;
    localparam int RES_W = MUL_W + 3;
    localparam logic signed [COORD_W-1:0] P_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] P_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << COORD_FRAC_BITS;

    logic                 adv;
    logic [DET_TOL_W-1:0] r_det_tol;
    logic [RES_TOL_W-1:0] r_res_tol;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_tol <= '0;
            r_res_tol <= RES_TOL_W'(16);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DET_TOL: r_det_tol <= DET_TOL_W'(i_cfg_data);
                CFG_RES_TOL: r_res_tol <= RES_TOL_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Advance unless a finished request waits on a stalled output
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // Stage 1: direction and offset vectors
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_d1[3];
    logic signed [DIFF_W-1:0] r_d2[3];
    logic signed [DIFF_W-1:0] r_w [3];
    logic [COORD_W-1:0]       a1[3];
    logic [COORD_W-1:0]       a2[3];
    logic [COORD_W-1:0]       b1[3];
    logic [COORD_W-1:0]       b2[3];

    always_comb begin
        a1[0] = i_in_item.first_start_x;  a1[1] = i_in_item.first_start_y;
        a1[2] = i_in_item.first_start_z;
        a2[0] = i_in_item.first_end_x;    a2[1] = i_in_item.first_end_y;
        a2[2] = i_in_item.first_end_z;
        b1[0] = i_in_item.second_start_x; b1[1] = i_in_item.second_start_y;
        b1[2] = i_in_item.second_start_z;
        b2[0] = i_in_item.second_end_x;   b2[1] = i_in_item.second_end_y;
        b2[2] = i_in_item.second_end_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_d1[k] <= {a2[k][COORD_W-1], a2[k]} - {a1[k][COORD_W-1], a1[k]};
                r_d2[k] <= {b2[k][COORD_W-1], b2[k]} - {b1[k][COORD_W-1], b1[k]};
                r_w[k]  <= {b1[k][COORD_W-1], b1[k]} - {a1[k][COORD_W-1], a1[k]};
            end
        end
    end

    // Stage 2: cross products of both projections
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_p[12];
    logic signed [DIFF_W-1:0] r_d1b[3];
    logic signed [DIFF_W-1:0] r_d2b[3];
    logic signed [DIFF_W-1:0] r_wb [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // xy: det, u, v as a - b pairs
            r_p[0]  <= r_d2[0] * r_d1[1];
            r_p[1]  <= r_d1[0] * r_d2[1];
            r_p[2]  <= r_d2[0] * r_w[1];
            r_p[3]  <= r_d2[1] * r_w[0];
            r_p[4]  <= r_d1[0] * r_w[1];
            r_p[5]  <= r_d1[1] * r_w[0];
            // xz
            r_p[6]  <= r_d2[0] * r_d1[2];
            r_p[7]  <= r_d1[0] * r_d2[2];
            r_p[8]  <= r_d2[0] * r_w[2];
            r_p[9]  <= r_d2[2] * r_w[0];
            r_p[10] <= r_d1[0] * r_w[2];
            r_p[11] <= r_d1[2] * r_w[0];
            r_d1b   <= r_d1;
            r_d2b   <= r_d2;
            r_wb    <= r_w;
        end
    end

    // Stage 3: determinants and numerators
    logic                     r_v3;
    logic signed [DET_W-1:0]  r_s[6];
    logic signed [DIFF_W-1:0] r_d1c[3];
    logic signed [DIFF_W-1:0] r_d2c[3];
    logic signed [DIFF_W-1:0] r_wc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 6; k++) begin
                r_s[k] <= DET_W'(r_p[2*k]) - DET_W'(r_p[2*k+1]);
            end
            r_d1c <= r_d1b;
            r_d2c <= r_d2b;
            r_wc  <= r_wb;
        end
    end

    // Stage 4: singularity test and system choice
    logic              r_v4;
    logic [DET_W-1:0]  r_num_u;
    logic [DET_W-1:0]  r_num_v;
    logic [DET_W-1:0]  r_den;
    t_side             r_side;
    logic [DET_W-1:0]  mag_xy;
    logic [DET_W-1:0]  mag_xz;
    logic              sing_xy;
    logic              sing_xz;
    logic signed [DET_W-1:0] sel_det;
    logic signed [DET_W-1:0] sel_u;
    logic signed [DET_W-1:0] sel_v;
    t_side             n_side;

    always_comb begin
        mag_xy  = abs_det(r_s[0]);
        mag_xz  = abs_det(r_s[3]);
        sing_xy = (mag_xy == '0) || (mag_xy < DET_W'(r_det_tol));
        sing_xz = (mag_xz == '0) || (mag_xz < DET_W'(r_det_tol));
        sel_det = sing_xy ? r_s[3] : r_s[0];
        sel_u   = sing_xy ? r_s[4] : r_s[1];
        sel_v   = sing_xy ? r_s[5] : r_s[2];
        n_side.solved = !sing_xy || !sing_xz;
        n_side.neg_u  = sel_u[DET_W-1] ^ sel_det[DET_W-1];
        n_side.neg_v  = sel_v[DET_W-1] ^ sel_det[DET_W-1];
        n_side.da     = sing_xy ? r_d1c[1] : r_d1c[2];
        n_side.db     = sing_xy ? r_d2c[1] : r_d2c[2];
        n_side.wc     = sing_xy ? r_wc[1]  : r_wc[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (adv) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num_u <= abs_det(sel_u);
            r_num_v <= abs_det(sel_v);
            r_den   <= sing_xy ? mag_xz : mag_xy;
            r_side  <= n_side;
        end
    end

    // Divider
    logic              dv_vld;
    logic [QUOT_W-1:0] dv_q_u;
    logic [QUOT_W-1:0] dv_q_v;
    logic              dv_ovf_u;
    logic              dv_ovf_v;
    t_side             dv_side;

    sid_div #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_v4),
        .i_num_u (r_num_u),
        .i_num_v (r_num_v),
        .i_den   (r_den),
        .i_side  (r_side),
        .o_vld   (dv_vld),
        .o_quot_u(dv_q_u),
        .o_ovf_u (dv_ovf_u),
        .o_quot_v(dv_q_v),
        .o_ovf_v (dv_ovf_v),
        .o_side  (dv_side)
    );

    // Saturate a signed quotient to the parameter range
    function automatic logic signed [COORD_W-1:0] sat_q(input logic [QUOT_W-1:0] q,
                                                        input logic ovf,
                                                        input logic neg);
        logic [QUOT_W-1:0] nq;
        nq = -q;
        if (neg) begin
            sat_q = (ovf || q > (QUOT_W'(1) << (COORD_W-1))) ? P_MIN : nq[COORD_W-1:0];
        end else begin
            sat_q = (ovf || q > QUOT_W'(P_MAX)) ? P_MAX : q[COORD_W-1:0];
        end
    endfunction

    // Saturation stage
    logic                      r_v5;
    logic signed [COORD_W-1:0] r_u5;
    logic signed [COORD_W-1:0] r_v5p;
    t_side                     r_side5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (adv) r_v5 <= dv_vld;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u5    <= dv_side.solved ? sat_q(dv_q_u, dv_ovf_u, dv_side.neg_u) : P_MAX;
            r_v5p   <= dv_side.solved ? sat_q(dv_q_v, dv_ovf_v, dv_side.neg_v) : P_MAX;
            r_side5 <= dv_side;
        end
    end

    // Multiply parameters back onto the check axis
    logic                      r_v6;
    logic signed [MUL_W-1:0]   r_pu;
    logic signed [MUL_W-1:0]   r_pv;
    logic signed [COORD_W-1:0] r_u6;
    logic signed [COORD_W-1:0] r_v6p;
    logic signed [DIFF_W-1:0]  r_w6;
    logic                      r_solved6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (adv) r_v6 <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pu      <= r_u5 * r_side5.da;
            r_pv      <= r_v5p * r_side5.db;
            r_u6      <= r_u5;
            r_v6p     <= r_v5p;
            r_w6      <= r_side5.wc;
            r_solved6 <= r_side5.solved;
        end
    end

    // Residual, range test and output register
    logic signed [RES_W-1:0] resid;
    logic [RES_W-1:0]        resid_mag;
    logic                    resid_ok;
    logic                    in_range;
    t_status                 n_status;
    t_out_item               r_out;
    logic                    r_out_vld;

    always_comb begin
        resid     = RES_W'(r_pu) - RES_W'(r_pv) - (RES_W'(r_w6) <<< COORD_FRAC_BITS);
        resid_mag = resid[RES_W-1] ? RES_W'(-resid) : RES_W'(resid);
        resid_ok  = resid_mag <= (RES_W'(r_res_tol) << COORD_FRAC_BITS);
        in_range  = !r_u6[COORD_W-1] && (r_u6 <= ONE)
                 && !r_v6p[COORD_W-1] && (r_v6p <= ONE);
        if (!r_solved6) n_status = ST_ON_LINE;
        else if (resid_ok && in_range) n_status = ST_YES;
        else n_status = ST_NO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (adv) r_out_vld <= r_v6;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.status       <= n_status;
            r_out.param_first  <= r_u6;
            r_out.param_second <= r_v6p;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

@@ src/sid_checker.sv @@
// Port-level checker of the segment intersection block, with its bind.
`include "segment_intersection_3d_defines.svh"

module sid_checker
    import sid_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [0:0]            i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [COORD_W-1:0] ONE  = COORD_W'(1) << COORD_FRAC_BITS;
    localparam logic [COORD_W-1:0] PMAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Hold a stalled request
    `SID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled output request changed")

    // Input stalls only behind a stalled result
    `SID_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a stalled result")

    // Unsolved systems report saturated parameters
    `SID_ASSERT_NOW(a_online_max, i_clk, i_rst_n, o_out_valid && o_out_item.status == ST_ON_LINE, o_out_item.param_first == PMAX && o_out_item.param_second == PMAX, "on_line without saturated parameters")

    // A crossing lies within both segments
    `SID_ASSERT_NOW(a_yes_range, i_clk, i_rst_n, o_out_valid && o_out_item.status == ST_YES, !o_out_item.param_first[COORD_W-1] && o_out_item.param_first <= ONE && !o_out_item.param_second[COORD_W-1] && o_out_item.param_second <= ONE, "crossing outside the unit range")

endmodule

bind segment_intersection_3d sid_checker #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_sid_checker (.*);
